### hw/rtl/lkv_pkg.sv
// shared constants and codes of the lru key/value cache
package lkv_pkg;

    // field widths
    localparam int CAP_W = 5;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // default table depth
    localparam int ENTRIES_DEF = 16;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // value returned on a lookup miss
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

endpackage

### hw/rtl/lkv_ram.sv
// generic single write port ram with registered read
module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement. Each item passes
// through the input transfer, then a scan in which a single key comparator walks the
// key/value ram one word at a time over every table slot, and then a writeback that updates
// ranks, valid bits and the ram; a get whose result register is still occupied waits in
// writeback until the previous result transfers. The input is taken only between items,
// while a pending result may still wait at the output. Valid bits clear at reset, so no
// clearing pass runs; capacity writes are taken at any time but belong between items.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [63:0]              s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]               s_tuser,   // [0] cmd
    // result channel
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [31:0]              m_tdata,   // [31:0] read_value
    output logic [0:0]               m_tuser,   // [0] hit
    // capacity register write
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
    localparam int KW   = lkv_pkg::KEY_W;
    localparam int VW   = lkv_pkg::VAL_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [lkv_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]             occ_reg, occ_next;
    logic [ENTRIES-1:0]        valid_reg, valid_next;
    logic [RW-1:0]             rank_reg [ENTRIES];
    logic [RW-1:0]             rank_next [ENTRIES];
    logic [RW-1:0]             rank_upd [ENTRIES];
    logic [RW-1:0]             rank_ins [ENTRIES];

    // item latched at the input transfer
    logic                      cmd_reg;
    logic [KW-1:0]             key_reg;
    logic [VW-1:0]             val_reg;

    // scan results
    logic                      found_reg, found_next;
    logic [IW-1:0]             slot_reg, slot_next;
    logic [VW-1:0]             hval_reg, hval_next;
    logic                      free_found_reg, free_found_next;
    logic [IW-1:0]             free_reg, free_next;
    logic [IW-1:0]             lru_reg, lru_next;

    // result register
    logic                      m_valid_reg;
    logic                      m_hit_reg;
    logic [VW-1:0]             m_val_reg;

    logic [CW-1:0]             cnt_m1;
    logic [IW-1:0]             cmp_idx;
    logic [CW-1:0]             occ_m1_full;
    logic [RW-1:0]             occ_m1;
    logic [CW-1:0]             occ_p1;
    logic                      full;
    logic                      ev_hit;
    logic                      ev_ins;
    logic [IW-1:0]             ins_slot;
    logic [RW-1:0]             hit_rank;
    logic                      key_eq;
    logic                      wb_go;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic [IW-1:0]             rd_addr;
    logic [KW+VW-1:0]          rd_data;

    // key/value storage, value in the upper half
    lkv_ram #(
        .WIDTH (KW + VW),
        .DEPTH (ENTRIES)
    ) u_kv_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({val_reg, key_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_val_reg;
    assign m_tuser   = m_hit_reg;

    // scan addressing: slot 0 is read while idle, then one slot ahead of the compare
    assign rd_addr = (state_reg == ST_SCAN) ? cnt_reg[IW-1:0] : '0;
    assign cnt_m1  = cnt_reg - CW'(1);
    assign cmp_idx = cnt_m1[IW-1:0];
    assign key_eq  = (rd_data[KW-1:0] == key_reg);

    // occupancy arithmetic
    assign occ_m1_full = occ_reg - CW'(1);
    assign occ_m1      = occ_m1_full[RW-1:0];
    assign occ_p1      = occ_reg + CW'(1);
    assign full        = (occ_reg == CW'(ENTRIES));
    assign ev_hit      = (CMPW'(occ_reg) > CMPW'(cap_reg));
    assign ev_ins      = (CMPW'(occ_p1) > CMPW'(cap_reg));
    assign ins_slot    = full ? lru_reg : free_reg;
    assign hit_rank    = rank_reg[slot_reg];

    // writeback proceeds unless a get finds the result register still occupied
    assign wb_go   = (state_reg == ST_WB) &&
                     ((cmd_reg == lkv_pkg::CMD_PUT) || !m_valid_reg || m_tready);
    assign wr_en   = wb_go && (cmd_reg == lkv_pkg::CMD_PUT);
    assign wr_addr = found_reg ? slot_reg : ins_slot;

    // candidate ranks per slot for a hit and for an insert
    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            if (IW'(j) == slot_reg) begin
                rank_upd[j] = '0;
            end else if (rank_reg[j] < hit_rank) begin
                rank_upd[j] = rank_reg[j] + RW'(1);
            end else begin
                rank_upd[j] = rank_reg[j];
            end
            if (IW'(j) == ins_slot) begin
                rank_ins[j] = '0;
            end else begin
                rank_ins[j] = rank_reg[j] + RW'(1);
            end
        end
    end

    // sequencer and shared key comparator
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        hval_next       = hval_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        lru_next        = lru_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next      = ST_SCAN;
                    cnt_next        = CW'(1);
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (valid_reg[cmp_idx] && key_eq && !found_reg) begin
                    found_next = 1'b1;
                    slot_next  = cmp_idx;
                    hval_next  = rd_data[KW+VW-1:KW];
                end
                if (!valid_reg[cmp_idx] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_next       = cmp_idx;
                end
                if (valid_reg[cmp_idx] && (rank_reg[cmp_idx] == occ_m1)) begin
                    lru_next = cmp_idx;
                end
                if (cnt_reg == CW'(ENTRIES)) begin
                    state_next = ST_WB;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_WB: begin
                if (wb_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // writeback of ranks, valid bits and occupancy
    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int j = 0; j < ENTRIES; j++) begin
            rank_next[j] = rank_reg[j];
        end
        if (wb_go) begin
            if (found_reg) begin
                // hit: move to front, a put may then evict the new tail
                for (int j = 0; j < ENTRIES; j++) begin
                    rank_next[j] = rank_upd[j];
                end
                if ((cmd_reg == lkv_pkg::CMD_PUT) && ev_hit) begin
                    for (int j = 0; j < ENTRIES; j++) begin
                        if (valid_reg[j] && (rank_upd[j] == occ_m1)) begin
                            valid_next[j] = 1'b0;
                        end
                    end
                    occ_next = occ_m1_full;
                end
            end else if (cmd_reg == lkv_pkg::CMD_PUT) begin
                // new key: a full table reuses the tail slot in place
                for (int j = 0; j < ENTRIES; j++) begin
                    rank_next[j] = rank_ins[j];
                end
                if (!full) begin
                    for (int j = 0; j < ENTRIES; j++) begin
                        if (valid_reg[j] && (rank_reg[j] == occ_m1) && ev_ins) begin
                            valid_next[j] = 1'b0;
                        end
                    end
                    valid_next[free_reg] = !(ev_ins && (occ_reg == '0));
                    occ_next = ev_ins ? occ_reg : occ_p1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= lkv_pkg::CAP_RESET;
            occ_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (wb_go && (cmd_reg == lkv_pkg::CMD_GET)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        hval_reg       <= hval_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        lru_reg        <= lru_next;
        for (int j = 0; j < ENTRIES; j++) begin
            rank_reg[j] <= rank_next[j];
        end
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tuser[0];
            key_reg <= s_tdata[KW-1:0];
            val_reg <= s_tdata[KW+VW-1:KW];
        end
        if (wb_go && (cmd_reg == lkv_pkg::CMD_GET)) begin
            m_hit_reg <= found_reg;
            m_val_reg <= found_reg ? hval_reg : lkv_pkg::MISS_VALUE;
        end
    end

    // occupancy always matches the number of valid slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy count out of step with valid bits");

    // occupancy never exceeds the table depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CW'(ENTRIES))
        else $error("occupancy above table depth");

    // a result only appears after a writeback cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_WB))
        else $error("result raised outside writeback");

    // a put never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wb_go && (cmd_reg == lkv_pkg::CMD_PUT) && !m_valid_reg) |=> !m_valid_reg)
        else $error("store produced a result");

endmodule
